// File: src/addressable_led_bit_encoder_top_macros.svh
// Assertion macros shared by the encoder modules.
// Each macro expects clk and rst_n in scope and is disabled during reset.
`ifndef ADDRESSABLE_LED_BIT_ENCODER_TOP_MACROS_SVH
`define ADDRESSABLE_LED_BIT_ENCODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALED_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aled assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ALED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aled assertion failed in the next cycle");

`endif

// File: src/aled_pkg.sv
package aled_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_TIMING_PROFILE   = 3'd0;
    localparam logic [2:0] REG_CUSTOM_ZERO_HIGH = 3'd1;
    localparam logic [2:0] REG_CUSTOM_ONE_HIGH  = 3'd2;
    localparam logic [2:0] REG_CUSTOM_ZERO_LOW  = 3'd3;
    localparam logic [2:0] REG_CUSTOM_ONE_LOW   = 3'd4;
    localparam logic [2:0] REG_RESET_GAP_US     = 3'd5;

    localparam logic [2:0] PROFILE_CUSTOM = 3'd7;

    localparam logic [8:0] GAP_MIN_US   = 9'd50;
    localparam logic [8:0] GAP_MAX_US   = 9'd500;
    localparam logic [8:0] GAP_RESET_US = 9'd150;

    // Segment slots of one byte: leading reset, sixteen bit segments, trailing reset.
    localparam logic [4:0] SEG_LEAD     = 5'd0;
    localparam logic [4:0] SEG_FIRST_BIT = 5'd1;
    localparam logic [4:0] SEG_LAST_BIT = 5'd16;
    localparam logic [4:0] SEG_TRAIL    = 5'd17;

    // Active bit timing and reset gap, handed from the register file to the sequencer.
    typedef struct packed {
        logic [7:0] zero_high;
        logic [7:0] one_high;
        logic [7:0] zero_low;
        logic [7:0] one_low;
        logic [8:0] gap_us;
    } timing_t;

    // Fixed profile table: returns {zero_high, one_high, zero_low, one_low}.
    function automatic logic [31:0] profile_lookup(input logic [2:0] profile);
        logic [31:0] row;
        unique case (profile)
            3'd0:    row = {8'd0, 8'd1, 8'd1, 8'd0};
            3'd1:    row = {8'd1, 8'd2, 8'd2, 8'd1};
            3'd2:    row = {8'd1, 8'd3, 8'd3, 8'd1};
            3'd3:    row = {8'd2, 8'd5, 8'd5, 8'd2};
            3'd4:    row = {8'd3, 8'd8, 8'd8, 8'd3};
            3'd5:    row = {8'd5, 8'd12, 8'd12, 8'd5};
            3'd6:    row = {8'd8, 8'd18, 8'd18, 8'd8};
            default: row = {8'd0, 8'd1, 8'd1, 8'd0};
        endcase
        return row;
    endfunction

endpackage

// File: src/aled_cfg_regs.sv
module aled_cfg_regs
    import aled_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    output timing_t    timing
);

    logic [2:0] profile_reg;
    logic [7:0] zero_high_reg;
    logic [7:0] one_high_reg;
    logic [7:0] zero_low_reg;
    logic [7:0] one_low_reg;
    logic [8:0] gap_reg;
    logic [8:0] gap_next;
    logic [31:0] fixed_row;

    // Out-of-range gap values are saturated into the legal window.
    always_comb
    begin
        if (cfg_data < GAP_MIN_US)
        begin
            gap_next = GAP_MIN_US;
        end
        else if (cfg_data > GAP_MAX_US)
        begin
            gap_next = GAP_MAX_US;
        end
        else
        begin
            gap_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg   <= 3'd2;
            zero_high_reg <= 8'd1;
            one_high_reg  <= 8'd3;
            zero_low_reg  <= 8'd3;
            one_low_reg   <= 8'd1;
            gap_reg       <= GAP_RESET_US;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIMING_PROFILE:   profile_reg   <= cfg_data[2:0];
                REG_CUSTOM_ZERO_HIGH: zero_high_reg <= cfg_data[7:0];
                REG_CUSTOM_ONE_HIGH:  one_high_reg  <= cfg_data[7:0];
                REG_CUSTOM_ZERO_LOW:  zero_low_reg  <= cfg_data[7:0];
                REG_CUSTOM_ONE_LOW:   one_low_reg   <= cfg_data[7:0];
                REG_RESET_GAP_US:     gap_reg       <= gap_next;
                default:              ;
            endcase
        end
    end

    assign fixed_row = profile_lookup(profile_reg);

    always_comb
    begin
        timing.gap_us = gap_reg;
        if (profile_reg == PROFILE_CUSTOM)
        begin
            timing.zero_high = zero_high_reg;
            timing.one_high  = one_high_reg;
            timing.zero_low  = zero_low_reg;
            timing.one_low   = one_low_reg;
        end
        else
        begin
            timing.zero_high = fixed_row[31:24];
            timing.one_high  = fixed_row[23:16];
            timing.zero_low  = fixed_row[15:8];
            timing.one_low   = fixed_row[7:0];
        end
    end

endmodule

// File: src/aled_seq.sv
`include "addressable_led_bit_encoder_top_macros.svh"

module aled_seq
    import aled_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  timing_t    timing,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] pixel_byte,
    input  logic       frame_start,
    input  logic       frame_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       line_level,
    output logic [8:0] segment_length,
    output logic       in_microseconds,
    output logic       run_end
);

    logic       busy_reg,  busy_next;
    logic [4:0] idx_reg,   idx_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       out_valid_reg, out_valid_next;
    logic       level_reg;
    logic [8:0] len_reg;
    logic       micro_reg;
    logic       end_reg;

    logic       issue;
    logic       is_last;
    logic       in_accept;
    logic [4:0] bit_pos;
    logic [2:0] bit_sel;
    logic       bit_one;
    logic       seg_level;
    logic [8:0] seg_len;
    logic       seg_micro;

    assign issue     = busy_reg && (!out_valid_reg || out_ready);
    assign is_last   = (idx_reg == SEG_TRAIL) || ((idx_reg == SEG_LAST_BIT) && !last_reg);
    assign in_ready  = !busy_reg || (issue && is_last);
    assign in_accept = in_valid && in_ready;

    // Bit segments come in high/low pairs, most significant bit first.
    assign bit_pos = idx_reg - SEG_FIRST_BIT;
    assign bit_sel = 3'd7 - bit_pos[3:1];
    assign bit_one = byte_reg[bit_sel];

    always_comb
    begin
        if ((idx_reg == SEG_LEAD) || (idx_reg == SEG_TRAIL))
        begin
            seg_level = 1'b0;
            seg_len   = timing.gap_us;
            seg_micro = 1'b1;
        end
        else
        begin
            seg_level = !bit_pos[0];
            seg_micro = 1'b0;
            if (seg_level)
            begin
                seg_len = {1'b0, bit_one ? timing.one_high : timing.zero_high};
            end
            else
            begin
                seg_len = {1'b0, bit_one ? timing.one_low : timing.zero_low};
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (issue)
        begin
            idx_next = idx_reg + 5'd1;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (in_accept)
        begin
            busy_next = 1'b1;
            idx_next  = frame_start ? SEG_LEAD : SEG_FIRST_BIT;
        end
        out_valid_next = issue ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= SEG_LEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= pixel_byte;
            last_reg <= frame_end;
        end
        if (issue)
        begin
            level_reg <= seg_level;
            len_reg   <= seg_len;
            micro_reg <= seg_micro;
            end_reg   <= is_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign line_level      = level_reg;
    assign segment_length  = len_reg;
    assign in_microseconds = micro_reg;
    assign run_end         = end_reg;

    `ALED_ASSERT_SAME(a_idx_range, busy_reg, idx_reg <= SEG_TRAIL)
    `ALED_ASSERT_SAME(a_accept_only_at_end, in_accept && busy_reg, issue && is_last)
    `ALED_ASSERT_NEXT(a_stay_busy, issue && !is_last, busy_reg)
    `ALED_ASSERT_SAME(a_reset_seg_low, out_valid_reg && micro_reg,
                      !level_reg && (len_reg >= GAP_MIN_US) && (len_reg <= GAP_MAX_US))

endmodule

// File: src/addressable_led_bit_encoder_top.sv
// Channel  | Direction | Handshake             | Payload
// request  | in        | in_valid / in_ready   | pixel_byte, frame_start, frame_end
// result   | out       | out_valid / out_ready | line_level, segment_length,
//          |           |                       | in_microseconds, run_end
// config   | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each request yields 16 to 18 result segments (16 + frame_start + frame_end),
// one per cycle unless out_ready stalls; the single segment sequencer issues them.
// The next request is taken in the cycle its predecessor issues its last segment.
// Reset (rst_n, asynchronous, active low) restores the register defaults and empties
// the sequencer and the result register. A stalled result holds in the result
// register while the sequencer waits; configuration writes are always taken.

`include "addressable_led_bit_encoder_top_macros.svh"

module addressable_led_bit_encoder_top
    import aled_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // Configuration write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    // Request channel.
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] pixel_byte,
    input  logic       frame_start,
    input  logic       frame_end,
    // Result channel.
    output logic       out_valid,
    input  logic       out_ready,
    output logic       line_level,
    output logic [8:0] segment_length,
    output logic       in_microseconds,
    output logic       run_end
);

    timing_t timing;

    // Register writes never stall; indexes beyond the register list are dropped.
    assign cfg_ready = 1'b1;

    // Register file: holds the custom timings and the gap, and resolves the
    // active profile into one set of four bit lengths.
    aled_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    // Sequencer: latches one request, walks its segment slots and drives the
    // result register, which decouples the two handshakes.
    aled_seq u_seq
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .timing          (timing),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_byte      (pixel_byte),
        .frame_start     (frame_start),
        .frame_end       (frame_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .line_level      (line_level),
        .segment_length  (segment_length),
        .in_microseconds (in_microseconds),
        .run_end         (run_end)
    );

    // The run_end flag closes every request, so a flagged segment is never a high one.
    `ALED_ASSERT_SAME(a_run_end_low, out_valid && run_end, !line_level)
    // A result that waits on a stalled consumer keeps its marker.
    `ALED_ASSERT_NEXT(a_stall_keeps_end, out_valid && !out_ready, $stable(run_end))
    // Register writes are never refused.
    `ALED_ASSERT_SAME(a_cfg_ready, 1'b1, cfg_ready)

endmodule
